// ===== rtl/ssrlm_pkg.sv =====
`default_nettype none
package ssrlm_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_LIN_VEL  = 3'd0,
		REG_MAX_ROT_VEL  = 3'd1,
		REG_MAX_LIN_STEP = 3'd2,
		REG_MAX_ROT_STEP = 3'd3,
		REG_INV_RADIUS   = 3'd4,
		REG_OFFSET_RATIO = 3'd5
	} reg_idx_t;

	localparam logic [14:0] RST_MAX_LIN_VEL  = 15'd256;
	localparam logic [14:0] RST_MAX_ROT_VEL  = 15'd256;
	localparam logic [14:0] RST_MAX_LIN_STEP = 15'd8;
	localparam logic [14:0] RST_MAX_ROT_STEP = 15'd8;
	localparam logic [15:0] RST_INV_RADIUS   = 16'd2560;
	localparam logic [15:0] RST_OFFSET_RATIO = 16'd1280;

	typedef struct packed {
		logic               mode;
		logic signed [15:0] forward_velocity;
		logic signed [15:0] rotational_velocity;
	} in_word_t;

	typedef struct packed {
		logic               wheel_mode;
		logic signed [23:0] left_wheel_speed;
		logic signed [23:0] right_wheel_speed;
	} out_word_t;

	typedef struct packed {
		logic [14:0] max_lin_vel;
		logic [14:0] max_rot_vel;
		logic [14:0] max_lin_step;
		logic [14:0] max_rot_step;
		logic [15:0] inv_radius;
		logic [15:0] offset_ratio;
	} cfg_t;

endpackage
`default_nettype wire

// ===== rtl/ssrlm_regs.sv =====
`default_nettype none
module ssrlm_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ssrlm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ssrlm_pkg::CFG_DATA_W-1:0]    cfg_data,
	output ssrlm_pkg::cfg_t                          cfg
);

	ssrlm_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_lin_vel  <= ssrlm_pkg::RST_MAX_LIN_VEL;
			cfg_q.max_rot_vel  <= ssrlm_pkg::RST_MAX_ROT_VEL;
			cfg_q.max_lin_step <= ssrlm_pkg::RST_MAX_LIN_STEP;
			cfg_q.max_rot_step <= ssrlm_pkg::RST_MAX_ROT_STEP;
			cfg_q.inv_radius   <= ssrlm_pkg::RST_INV_RADIUS;
			cfg_q.offset_ratio <= ssrlm_pkg::RST_OFFSET_RATIO;
		end else if (cfg_valid && cfg_ready) begin
			// Writes to an index past the last register are dropped.
			case (cfg_index)
				ssrlm_pkg::REG_MAX_LIN_VEL:  cfg_q.max_lin_vel  <= cfg_data[14:0];
				ssrlm_pkg::REG_MAX_ROT_VEL:  cfg_q.max_rot_vel  <= cfg_data[14:0];
				ssrlm_pkg::REG_MAX_LIN_STEP: cfg_q.max_lin_step <= cfg_data[14:0];
				ssrlm_pkg::REG_MAX_ROT_STEP: cfg_q.max_rot_step <= cfg_data[14:0];
				ssrlm_pkg::REG_INV_RADIUS:   cfg_q.inv_radius   <= cfg_data;
				ssrlm_pkg::REG_OFFSET_RATIO: cfg_q.offset_ratio <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ssrlm_limit.sv =====
`default_nettype none
module ssrlm_limit (
	input  wire logic signed [15:0] req,
	input  wire logic signed [15:0] last,
	input  wire logic        [14:0] step,
	input  wire logic        [14:0] vmax,
	output logic signed [15:0]      nxt
);

	logic signed [17:0] diff;
	logic signed [17:0] step_s;
	logic signed [17:0] vmax_s;
	logic signed [17:0] d_lim;
	logic signed [17:0] sum;
	logic signed [17:0] res;

	always_comb begin
		diff   = {{2{req[15]}}, req} - {{2{last[15]}}, last};
		step_s = {3'b000, step};
		vmax_s = {3'b000, vmax};
		if (diff > step_s) begin
			d_lim = step_s;
		end else if (diff < -step_s) begin
			d_lim = -step_s;
		end else begin
			d_lim = diff;
		end
		sum = {{2{last[15]}}, last} + d_lim;
		if (sum > vmax_s) begin
			res = vmax_s;
		end else if (sum < -vmax_s) begin
			res = -vmax_s;
		end else begin
			res = sum;
		end
		// The velocity clamp keeps the result inside 16 signed bits.
		nxt = res[15:0];
	end

endmodule
`default_nettype wire

// ===== rtl/ssrlm_mix.sv =====
`default_nettype none
module ssrlm_mix (
	input  wire logic signed [15:0] v,
	input  wire logic signed [15:0] w,
	input  wire logic        [15:0] inv_radius,
	input  wire logic        [15:0] offset_ratio,
	output logic signed [23:0]      left,
	output logic signed [23:0]      right
);

	logic signed [32:0] lin;
	logic signed [32:0] rot;
	logic signed [33:0] lsum;
	logic signed [33:0] rsum;

	function automatic logic signed [23:0] sat24(input logic signed [25:0] q);
		logic signed [23:0] r;
		if (q > 26'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (q < -26'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = q[23:0];
		end
		return r;
	endfunction

	always_comb begin
		lin  = 33'(v) * 33'($signed({1'b0, inv_radius}));
		rot  = 33'(w) * 33'($signed({1'b0, offset_ratio}));
		// Adding half an LSB and dropping eight bits rounds ties upward.
		lsum = {lin[32], lin} - {rot[32], rot} + 34'sd128;
		rsum = {lin[32], lin} + {rot[32], rot} + 34'sd128;
		left  = sat24(lsum[33:8]);
		right = sat24(rsum[33:8]);
	end

endmodule
`default_nettype wire

// ===== rtl/skid_steer_rate_limited_mixer_top.sv =====
`default_nettype none
// Channel   Direction  Handshake            Word
// in        to block   in_valid/in_stall    mode, forward and yaw velocity
// out       from block out_valid/out_stall  wheel mode, left and right speed
// cfg       to block   cfg_valid/cfg_ready  register index and write data
//
// Three register stages: input, limited twist, wheel speeds; one word is taken
// every cycle while in_stall is low. The slew and clamp logic with the stored
// last values is combinational, so a new word enters while older ones move on.
// Reset restores the register defaults and clears the last values.
// A stall on the output fills the stages one by one before in_stall rises.
// cfg_ready is always high.
module skid_steer_rate_limited_mixer_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire ssrlm_pkg::in_word_t              in_data,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output ssrlm_pkg::out_word_t                  out_data,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [ssrlm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ssrlm_pkg::CFG_DATA_W-1:0] cfg_data
);

	ssrlm_pkg::cfg_t     cfg;
	ssrlm_pkg::in_word_t word_s1;
	logic                valid_s1;
	logic                valid_s2;
	logic                mode_s2;
	logic signed [15:0]  v_s2;
	logic signed [15:0]  w_s2;
	logic signed [15:0]  last_fwd_q;
	logic signed [15:0]  last_rot_q;
	logic signed [15:0]  v_nxt;
	logic signed [15:0]  w_nxt;
	logic signed [23:0]  left;
	logic signed [23:0]  right;
	logic                adv_out;
	logic                adv2;
	logic                adv1;

	ssrlm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ssrlm_limit u_lim_fwd (
		.req  (word_s1.forward_velocity),
		.last (last_fwd_q),
		.step (cfg.max_lin_step),
		.vmax (cfg.max_lin_vel),
		.nxt  (v_nxt)
	);

	ssrlm_limit u_lim_rot (
		.req  (word_s1.rotational_velocity),
		.last (last_rot_q),
		.step (cfg.max_rot_step),
		.vmax (cfg.max_rot_vel),
		.nxt  (w_nxt)
	);

	ssrlm_mix u_mix (
		.v            (v_s2),
		.w            (w_s2),
		.inv_radius   (cfg.inv_radius),
		.offset_ratio (cfg.offset_ratio),
		.left         (left),
		.right        (right)
	);

	assign adv_out  = !out_valid || !out_stall;
	assign adv2     = !valid_s2 || adv_out;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			out_valid  <= 1'b0;
			last_fwd_q <= '0;
			last_rot_q <= '0;
		end else begin
			if (adv1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_out) begin
				out_valid <= valid_s2;
			end
			// The last values move only when a word leaves the input stage.
			if (valid_s1 && adv2) begin
				if (word_s1.mode) begin
					last_fwd_q <= '0;
					last_rot_q <= '0;
				end else begin
					last_fwd_q <= v_nxt;
					last_rot_q <= w_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			word_s1 <= in_data;
		end
		if (adv2 && valid_s1) begin
			mode_s2 <= word_s1.mode;
			v_s2    <= word_s1.mode ? 16'sd0 : v_nxt;
			w_s2    <= word_s1.mode ? 16'sd0 : w_nxt;
		end
		if (adv_out && valid_s2) begin
			out_data.wheel_mode        <= mode_s2;
			out_data.left_wheel_speed  <= left;
			out_data.right_wheel_speed <= right;
		end
	end

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_valid && out_stall))
		else $error("input stalled while the pipeline had room");

	a_freeze_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv2 && word_s1.mode) |=> (last_fwd_q == 16'sd0 && last_rot_q == 16'sd0))
		else $error("freeze word did not clear the last values");

	a_freeze_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.wheel_mode) |->
		(out_data.left_wheel_speed == 24'sd0 && out_data.right_wheel_speed == 24'sd0))
		else $error("freeze result carries a nonzero wheel speed");

	a_s2_freeze_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && mode_s2) |-> (v_s2 == 16'sd0 && w_s2 == 16'sd0))
		else $error("freeze word reached the mixer with a nonzero twist");

endmodule
`default_nettype wire

// ===== test/skid_steer_rate_limited_mixer_top_test.sv =====
`timescale 1ns / 1ps
module skid_steer_rate_limited_mixer_top_test;

	localparam logic MODE_TWIST  = 1'b0;
	localparam logic MODE_FREEZE = 1'b1;

	// The index field is wider than the register list; these two do nothing.
	localparam logic [ssrlm_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [ssrlm_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int PHASES      = 6;
	localparam int PHASE_WORDS = 150;
	localparam int DRAIN_LIMIT = 2000;

	class wheel_speed_board;
		int lin_vmax, rot_vmax, lin_step, rot_step, inv_radius, offset_ratio;
		int last_fwd, last_rot;
		ssrlm_pkg::out_word_t speeds_due[$];
		int errors, words_in, words_out;

		function new();
			lin_vmax     = int'(ssrlm_pkg::RST_MAX_LIN_VEL);
			rot_vmax     = int'(ssrlm_pkg::RST_MAX_ROT_VEL);
			lin_step     = int'(ssrlm_pkg::RST_MAX_LIN_STEP);
			rot_step     = int'(ssrlm_pkg::RST_MAX_ROT_STEP);
			inv_radius   = int'(ssrlm_pkg::RST_INV_RADIUS);
			offset_ratio = int'(ssrlm_pkg::RST_OFFSET_RATIO);
			last_fwd     = 0;
			last_rot     = 0;
			errors       = 0;
			words_in     = 0;
			words_out    = 0;
		endfunction

		function void set_reg(logic [ssrlm_pkg::CFG_IDX_W-1:0] idx,
				logic [ssrlm_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				ssrlm_pkg::REG_MAX_LIN_VEL:  lin_vmax     = int'(data[14:0]);
				ssrlm_pkg::REG_MAX_ROT_VEL:  rot_vmax     = int'(data[14:0]);
				ssrlm_pkg::REG_MAX_LIN_STEP: lin_step     = int'(data[14:0]);
				ssrlm_pkg::REG_MAX_ROT_STEP: rot_step     = int'(data[14:0]);
				ssrlm_pkg::REG_INV_RADIUS:   inv_radius   = int'(data);
				ssrlm_pkg::REG_OFFSET_RATIO: offset_ratio = int'(data);
				default: ;
			endcase
		endfunction

		function int clamp_sym(int x, int lim);
			if (x > lim)
				return lim;
			if (x < -lim)
				return -lim;
			return x;
		endfunction

		// Slew limit first, then the velocity clamp.
		function int limit_axis(int req, int last, int step, int vmax);
			return clamp_sym(last + clamp_sym(req - last, step), vmax);
		endfunction

		// Half up rounding from Q16.16 to Q16.8; the arithmetic shift is a floor.
		function logic signed [23:0] round_sat(longint x);
			longint q;
			q = (x + 64'sd128) >>> 8;
			if (q > 64'sd8388607)
				q = 64'sd8388607;
			else if (q < -64'sd8388608)
				q = -64'sd8388608;
			return q[23:0];
		endfunction

		function ssrlm_pkg::out_word_t mix_twist(ssrlm_pkg::in_word_t w);
			ssrlm_pkg::out_word_t r;
			longint lin, rot;
			if (w.mode == MODE_FREEZE) begin
				last_fwd = 0;
				last_rot = 0;
				r.wheel_mode = MODE_FREEZE;
				r.left_wheel_speed = '0;
				r.right_wheel_speed = '0;
				return r;
			end
			last_fwd = limit_axis(int'(w.forward_velocity), last_fwd, lin_step, lin_vmax);
			last_rot = limit_axis(int'(w.rotational_velocity), last_rot, rot_step, rot_vmax);
			lin = longint'(last_fwd) * longint'(inv_radius);
			rot = longint'(last_rot) * longint'(offset_ratio);
			r.wheel_mode = MODE_TWIST;
			r.left_wheel_speed = round_sat(lin - rot);
			r.right_wheel_speed = round_sat(lin + rot);
			return r;
		endfunction

		task note_word(ssrlm_pkg::in_word_t w);
			speeds_due.push_back(mix_twist(w));
			words_in++;
		endtask

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_result(ssrlm_pkg::out_word_t got);
			ssrlm_pkg::out_word_t want;
			words_out++;
			if (speeds_due.size() == 0) begin
				report($sformatf("word with nothing due: mode %0d left %0d right %0d",
					got.wheel_mode, got.left_wheel_speed, got.right_wheel_speed));
				return;
			end
			want = speeds_due.pop_front();
			if (got.wheel_mode !== want.wheel_mode)
				report($sformatf("wheel_mode %0d, due %0d", got.wheel_mode, want.wheel_mode));
			if (got.left_wheel_speed !== want.left_wheel_speed)
				report($sformatf("left speed %0d, due %0d",
					got.left_wheel_speed, want.left_wheel_speed));
			if (got.right_wheel_speed !== want.right_wheel_speed)
				report($sformatf("right speed %0d, due %0d",
					got.right_wheel_speed, want.right_wheel_speed));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	ssrlm_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	ssrlm_pkg::out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ssrlm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ssrlm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	bit gaps_on = 1'b1;
	int settings_run = 0;
	wheel_speed_board board = new();

	skid_steer_rate_limited_mixer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= gaps_on && ($urandom_range(99) < 15);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(out_data);
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic ssrlm_pkg::in_word_t make_word(logic mode, int fwd, int rot);
		ssrlm_pkg::in_word_t w;
		w.mode = mode;
		w.forward_velocity = 16'(fwd);
		w.rotational_velocity = 16'(rot);
		return w;
	endfunction

	function automatic int pick_velocity(int last);
		case ($urandom_range(5))
			0: return 32767;
			1: return -32768;
			2: return last + $urandom_range(0, 64) - 32;
			3: return $urandom_range(0, 1024) - 512;
			4: return 0;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic logic [ssrlm_pkg::CFG_DATA_W-1:0] pick_reg_value();
		case ($urandom_range(6))
			0: return '0;
			1: return '1;
			2: return 16'($urandom_range(1, 64));
			3: return 16'($urandom_range(1, 1024));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Every task below is entered at a falling edge and returns at one.
	task automatic drive_word(ssrlm_pkg::in_word_t w);
		while (gaps_on && $urandom_range(99) < 15) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = w;
		do
			@(posedge clk);
		while (in_stall);
		board.note_word(w);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [ssrlm_pkg::CFG_IDX_W-1:0] idx,
			logic [ssrlm_pkg::CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do
			@(posedge clk);
		while (!cfg_ready);
		board.set_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Waits for every due word, then for the pipeline depth and a little more.
	task automatic settle();
		int waited;
		waited = 0;
		in_valid = 1'b0;
		while (board.speeds_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (board.speeds_due.size() != 0)
			board.report($sformatf("%0d words never arrived", board.speeds_due.size()));
		repeat (6) @(negedge clk);
	endtask

	task automatic set_all_regs(logic [ssrlm_pkg::CFG_DATA_W-1:0] lin_v,
			logic [ssrlm_pkg::CFG_DATA_W-1:0] rot_v,
			logic [ssrlm_pkg::CFG_DATA_W-1:0] lin_s,
			logic [ssrlm_pkg::CFG_DATA_W-1:0] rot_s,
			logic [ssrlm_pkg::CFG_DATA_W-1:0] inv_r,
			logic [ssrlm_pkg::CFG_DATA_W-1:0] off_r);
		settle();
		write_reg(ssrlm_pkg::REG_MAX_LIN_VEL, lin_v);
		write_reg(ssrlm_pkg::REG_MAX_ROT_VEL, rot_v);
		write_reg(ssrlm_pkg::REG_MAX_LIN_STEP, lin_s);
		write_reg(ssrlm_pkg::REG_MAX_ROT_STEP, rot_s);
		write_reg(ssrlm_pkg::REG_INV_RADIUS, inv_r);
		write_reg(ssrlm_pkg::REG_OFFSET_RATIO, off_r);
		settings_run++;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Defaults after reset: the slew limit of eight shows on the first words.
		settings_run++;
		drive_word(make_word(MODE_TWIST, 0, 0));
		repeat (3) drive_word(make_word(MODE_TWIST, 32767, 32767));
		drive_word(make_word(MODE_TWIST, -32768, -32768));
		drive_word(make_word(MODE_FREEZE, $urandom_range(0, 65535), $urandom_range(0, 65535)));
		drive_word(make_word(MODE_TWIST, 100, -100));

		// All limits wide open; the wheel speeds saturate. The top data bit is dropped
		// by the fifteen bit registers, and the spare indexes are ignored.
		set_all_regs('1, '1, '1, '1, '1, '1);
		write_reg(REG_SPARE_LO, '0);
		write_reg(REG_SPARE_HI, '0);
		drive_word(make_word(MODE_TWIST, 32767, -32768));
		drive_word(make_word(MODE_TWIST, -32768, 32767));
		drive_word(make_word(MODE_TWIST, 32767, 32767));
		drive_word(make_word(MODE_FREEZE, -1, -1));
		drive_word(make_word(MODE_TWIST, 300, -300));

		// With no step allowed both axes hold their last values.
		settle();
		write_reg(ssrlm_pkg::REG_MAX_LIN_STEP, '0);
		write_reg(ssrlm_pkg::REG_MAX_ROT_STEP, '0);
		drive_word(make_word(MODE_TWIST, -5000, 5000));
		drive_word(make_word(MODE_TWIST, 32767, -32768));

		// A zero velocity limit forces the axis to zero.
		settle();
		write_reg(ssrlm_pkg::REG_MAX_LIN_VEL, '0);
		write_reg(ssrlm_pkg::REG_MAX_ROT_VEL, '0);
		drive_word(make_word(MODE_TWIST, 300, -300));

		// Tiny gains put the rounding on display: exact halves go up.
		set_all_regs('1, '1, '1, '1, 16'd1, 16'd1);
		drive_word(make_word(MODE_TWIST, 128, 0));
		drive_word(make_word(MODE_TWIST, -128, 0));
		drive_word(make_word(MODE_TWIST, -129, 0));
		drive_word(make_word(MODE_TWIST, 127, 0));
		drive_word(make_word(MODE_TWIST, 0, 128));
		drive_word(make_word(MODE_TWIST, 0, -128));

		for (int p = 0; p < PHASES; p++) begin
			set_all_regs(pick_reg_value(), pick_reg_value(), pick_reg_value(),
				pick_reg_value(), pick_reg_value(), pick_reg_value());
			if ($urandom_range(1))
				write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, pick_reg_value());
			gaps_on = (p != 2);
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if ($urandom_range(99) < 8)
					drive_word(make_word(MODE_FREEZE, $urandom_range(0, 65535),
						$urandom_range(0, 65535)));
				else
					drive_word(make_word(MODE_TWIST, pick_velocity(board.last_fwd),
						pick_velocity(board.last_rot)));
			end
		end
		gaps_on = 1'b1;

		settle();
		$display("%0d twist and freeze words sent, %0d wheel speed words checked",
			board.words_in, board.words_out);
		$display("%0d register settings used, %0d mismatches", settings_run, board.errors);
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ssrlm_pkg.sv
rtl/ssrlm_regs.sv
rtl/ssrlm_limit.sv
rtl/ssrlm_mix.sv
rtl/skid_steer_rate_limited_mixer_top.sv
test/skid_steer_rate_limited_mixer_top_test.sv
